FILE: hdl/mom_pkg.sv
// package for the multichannel oscillation meter
// request structs, result struct, sequencer states and constants; no dependencies
package mom_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ChBits      = 4;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned TimeBits    = 48;
  localparam int unsigned FreqBits    = 36;
  localparam int unsigned PhaseBits   = 16;
  localparam int unsigned CntBits     = 5;
  localparam int unsigned DivBits     = 36;

  localparam logic [15:0] FullTurn = 16'd46080;
  localparam logic [15:0] HalfTurn = 16'd23040;
  localparam logic [35:0] FreqNum  = 36'd65536000000;

  localparam logic [1:0] RegChannelCount = 2'd0;
  localparam logic [1:0] RegFreqEnable   = 2'd1;
  localparam logic [1:0] RegPhaseEnable  = 2'd2;

  typedef struct packed {
    logic [ChBits-1:0]            channel;
    logic signed [SampleBits-1:0] sample_value;
    logic [TimeBits-1:0]          timestamp;
  } in_t;

  typedef struct packed {
    logic                        result_kind;
    logic [ChBits-1:0]           source_channel;
    logic [ChBits-1:0]           other_channel;
    logic [FreqBits-1:0]         frequency_q16;
    logic [PhaseBits-1:0]        phase_full;
    logic signed [PhaseBits-1:0] phase_wrapped;
    logic                        last_of_run;
  } out_t;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StCheck,
    StNextJ,
    StMod,
    StRatio,
    StRatioEnd,
    StPhaseOut,
    StFreq,
    StFreqOut,
    StWait
  } state_e;

endpackage

FILE: hdl/multichannel_oscillation_meter.sv
// multichannel oscillation meter: one request is a timestamped sample for one channel; a peak
// yields phase results to higher channels and a frequency result, each when enabled. one bit-serial
// remainder unit (shift, compare, subtract per cycle) does all modulo, ratio and divide work.
// requests are refused until the last result has been taken.
// depends on mom_pkg
module multichannel_oscillation_meter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [4:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mom_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output mom_pkg::out_t   out_data_o
);

  localparam int unsigned TB = mom_pkg::TimeBits;

  logic [mom_pkg::CntBits-1:0] count_q;
  logic freq_en_q, phase_en_q;

  logic signed [mom_pkg::SampleBits-1:0] older_q [mom_pkg::MaxChannels];
  logic signed [mom_pkg::SampleBits-1:0] prev_q  [mom_pkg::MaxChannels];
  logic [TB-1:0] peak_q [mom_pkg::MaxChannels];

  mom_pkg::state_e state_q, state_d;
  mom_pkg::in_t    req_q;
  logic [mom_pkg::CntBits-1:0] eff_cnt;
  logic [mom_pkg::ChBits-1:0]  j_q;
  logic [TB-1:0]  period_q, q_q, rem_q;
  logic [TB-1:0]  pj;
  logic [5:0]     bit_q;
  logic [mom_pkg::FreqBits-1:0] acc_q;
  logic           peak_q_f;
  mom_pkg::out_t  res_q;
  logic           out_v_q;
  logic           last_run_q;

  // remainder step: 2*rem mod p
  logic [TB:0] dbl;
  logic [TB:0] pmq;
  logic        j_more;

  always_comb begin
    eff_cnt = count_q;
    if (count_q == '0) eff_cnt = 5'd1;
    if (count_q > 5'(mom_pkg::MaxChannels)) eff_cnt = 5'(mom_pkg::MaxChannels);
  end

  assign pj     = req_q.timestamp - peak_q[j_q];
  assign dbl    = {rem_q, 1'b0};
  assign pmq    = {1'b0, period_q};
  assign j_more = ({1'b0, j_q} + 5'd1) < eff_cnt && j_q != 4'(mom_pkg::MaxChannels - 1);
  assign in_ready_o  = (state_q == mom_pkg::StIdle);
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mom_pkg::StIdle:     if (in_valid_i) state_d = mom_pkg::StRead;
      mom_pkg::StRead:     state_d = mom_pkg::StCheck;
      mom_pkg::StCheck: begin
        if (!peak_q_f) state_d = mom_pkg::StIdle;
        else if (phase_en_q && period_q != '0 && j_more) state_d = mom_pkg::StNextJ;
        else if (freq_en_q) state_d = mom_pkg::StFreq;
        else state_d = mom_pkg::StIdle;
      end
      mom_pkg::StNextJ:    state_d = mom_pkg::StMod;
      mom_pkg::StMod:      if (bit_q == '0) state_d = mom_pkg::StRatio;
      mom_pkg::StRatio:    if (bit_q == '0) state_d = mom_pkg::StRatioEnd;
      mom_pkg::StRatioEnd: state_d = mom_pkg::StPhaseOut;
      mom_pkg::StPhaseOut: state_d = mom_pkg::StWait;
      mom_pkg::StFreq:     if (bit_q == '0) state_d = mom_pkg::StFreqOut;
      mom_pkg::StFreqOut:  state_d = mom_pkg::StWait;
      mom_pkg::StWait: begin
        if (out_v_q && out_ready_i) begin
          if (last_run_q) state_d = mom_pkg::StIdle;
          else if (j_more) state_d = mom_pkg::StNextJ;
          else state_d = mom_pkg::StFreq;
        end
      end
      default:             state_d = mom_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mom_pkg::StIdle;
      count_q   <= 5'd16;
      freq_en_q <= 1'b0;
      phase_en_q <= 1'b0;
      out_v_q   <= 1'b0;
      for (int c = 0; c < mom_pkg::MaxChannels; c++) begin
        older_q[c] <= '0;
        prev_q[c]  <= '0;
        peak_q[c]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mom_pkg::RegChannelCount: count_q <= cfg_data_i;
          mom_pkg::RegFreqEnable:   freq_en_q <= cfg_data_i[0];
          mom_pkg::RegPhaseEnable:  phase_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      unique case (state_q)
        mom_pkg::StIdle: if (in_valid_i) req_q <= in_data_i;
        mom_pkg::StRead: begin
          if ({1'b0, req_q.channel} < eff_cnt) begin
            older_q[req_q.channel] <= prev_q[req_q.channel];
            prev_q[req_q.channel]  <= req_q.sample_value;
          end
          peak_q_f <= ({1'b0, req_q.channel} < eff_cnt)
                      && (freq_en_q || phase_en_q)
                      && older_q[req_q.channel] < prev_q[req_q.channel]
                      && prev_q[req_q.channel] > req_q.sample_value;
          period_q <= req_q.timestamp - peak_q[req_q.channel];
          j_q      <= req_q.channel;
        end
        mom_pkg::StCheck: begin
          if (peak_q_f) begin
            if (phase_en_q && period_q != '0 && j_more) begin
              j_q <= j_q + 4'd1;
            end else if (freq_en_q) begin
              rem_q <= '0; acc_q <= '0; bit_q <= 6'd35;
            end else begin
              peak_q[req_q.channel] <= req_q.timestamp;
            end
          end
        end
        mom_pkg::StNextJ: begin
          q_q <= pj; rem_q <= '0; bit_q <= 6'(TB - 1);
        end
        mom_pkg::StMod: begin
          // rem = (2*rem + bit) mod p, restoring
          logic [TB:0] t;
          logic [TB-1:0] r;
          t = dbl | (TB+1)'(q_q[bit_q]);
          r = (t >= pmq) ? TB'(t - pmq) : TB'(t);
          if (bit_q == '0) begin
            q_q   <= period_q - r;
            bit_q <= 6'd15;
            acc_q <= '0;
            rem_q <= '0;
          end else begin
            rem_q <= r;
            bit_q <= bit_q - 6'd1;
          end
        end
        mom_pkg::StRatio: begin
          logic [TB-1:0] r1;
          logic [mom_pkg::FreqBits-1:0] a1;
          a1 = {acc_q[mom_pkg::FreqBits-2:0], 1'b0};
          if ({1'b0, rem_q} >= pmq - {1'b0, rem_q}) begin
            r1 = rem_q - (period_q - rem_q); a1 = a1 + 1'b1;
          end else r1 = rem_q + rem_q;
          if (mom_pkg::FullTurn[bit_q[3:0]]) begin
            if (q_q >= period_q) a1 = a1 + 1'b1;
            else if (r1 >= period_q - q_q) begin
              r1 = r1 - (period_q - q_q); a1 = a1 + 1'b1;
            end else r1 = r1 + q_q;
          end
          rem_q <= r1; acc_q <= a1;
          bit_q <= bit_q - 6'd1;
        end
        mom_pkg::StRatioEnd: begin
          if ({1'b0, rem_q} >= pmq - {1'b0, rem_q}) acc_q <= acc_q + 1'b1;
        end
        mom_pkg::StPhaseOut: begin
          logic [15:0] f;
          f = acc_q[15:0];
          res_q.result_kind    <= 1'b0;
          res_q.source_channel <= req_q.channel;
          res_q.other_channel  <= j_q;
          res_q.frequency_q16  <= '0;
          res_q.phase_full     <= f;
          res_q.phase_wrapped  <= (f >= mom_pkg::HalfTurn) ? f - mom_pkg::FullTurn : f;
          res_q.last_of_run    <= !j_more && !freq_en_q;
          last_run_q <= !j_more && !freq_en_q;
          out_v_q <= 1'b1;
        end
        mom_pkg::StFreq: begin
          logic [TB:0] t;
          t = dbl | (TB+1)'(mom_pkg::FreqNum[bit_q]);
          if (t >= pmq) begin
            rem_q <= TB'(t - pmq);
            acc_q <= {acc_q[mom_pkg::FreqBits-2:0], 1'b1};
          end else begin
            rem_q <= TB'(t);
            acc_q <= {acc_q[mom_pkg::FreqBits-2:0], 1'b0};
          end
          bit_q <= bit_q - 6'd1;
        end
        mom_pkg::StFreqOut: begin
          res_q.result_kind    <= 1'b1;
          res_q.source_channel <= req_q.channel;
          res_q.other_channel  <= '0;
          res_q.frequency_q16  <= (period_q == '0) ? '0 :
              (({1'b0, rem_q} >= pmq - {1'b0, rem_q}) ? acc_q + 1'b1 : acc_q);
          res_q.phase_full     <= '0;
          res_q.phase_wrapped  <= '0;
          res_q.last_of_run    <= 1'b1;
          last_run_q <= 1'b1;
          out_v_q <= 1'b1;
        end
        mom_pkg::StWait: begin
          if (out_v_q && out_ready_i) begin
            if (last_run_q) begin
              peak_q[req_q.channel] <= req_q.timestamp;
            end else if (j_more) begin
              j_q <= j_q + 4'd1;
            end else begin
              rem_q <= '0; acc_q <= '0; bit_q <= 6'd35;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
